[sv/tsn_pkg.sv]
// Shared constants, register codes and helpers for the texture sampler.
// Used by tsn_texmem and texture_sampler_nearest_bilinear_core.
package tsn_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int ADDR_BITS  = 16;
	localparam int TEXEL_BITS = 32;
	localparam int COORD_BITS = 24;
	localparam int DIM_BITS   = 9;
	localparam int IDX_BITS   = 8;
	localparam int WC_BITS    = FRAC_BITS + 1;
	localparam int PADDR_BITS = 5;

	localparam logic [WC_BITS-1:0]  ONE_FX  = WC_BITS'(1) << FRAC_BITS;
	localparam logic [DIM_BITS-1:0] MAX_DIM = DIM_BITS'(256);

	localparam logic [2:0] REG_TEX_WIDTH  = 3'd0;
	localparam logic [2:0] REG_TEX_HEIGHT = 3'd1;
	localparam logic [2:0] REG_WRAP_U     = 3'd2;
	localparam logic [2:0] REG_WRAP_V     = 3'd3;
	localparam logic [2:0] REG_FILTER     = 3'd4;
	localparam logic [2:0] REG_PRESENT    = 3'd5;

	localparam logic FUNC_WRITE  = 1'b0;
	localparam logic FUNC_SAMPLE = 1'b1;

	typedef logic [TEXEL_BITS-1:0] texel_t;
	typedef logic [ADDR_BITS-1:0]  taddr_t;

	function automatic logic [DIM_BITS-1:0] eff_dim(input logic [DIM_BITS-1:0] d);
		logic [DIM_BITS-1:0] r;
		r = d;
		if (d == '0)
			r = DIM_BITS'(1);
		else if (d > MAX_DIM)
			r = MAX_DIM;
		return r;
	endfunction

	function automatic logic [WC_BITS-1:0] wrap_coord(input logic signed [COORD_BITS-1:0] c,
		input logic clamp);
		logic [WC_BITS-1:0] r;
		r = {1'b0, c[FRAC_BITS-1:0]};
		if (clamp) begin
			if (c < 0)
				r = '0;
			else if (c > $signed({{(COORD_BITS-WC_BITS){1'b0}}, ONE_FX}))
				r = ONE_FX;
			else
				r = c[WC_BITS-1:0];
		end
		return r;
	endfunction

endpackage

[sv/tsn_texmem.sv]
// Texel store: two mirrored copies of the RGBA8 array, four registered reads.
// Depends on tsn_pkg.
module tsn_texmem (
	input  logic            clk,
	input  logic            en,
	input  logic            we,
	input  tsn_pkg::taddr_t waddr,
	input  tsn_pkg::texel_t wdata,
	input  tsn_pkg::taddr_t raddr00,
	input  tsn_pkg::taddr_t raddr10,
	input  tsn_pkg::taddr_t raddr01,
	input  tsn_pkg::taddr_t raddr11,
	output tsn_pkg::texel_t rdata00,
	output tsn_pkg::texel_t rdata10,
	output tsn_pkg::texel_t rdata01,
	output tsn_pkg::texel_t rdata11
);
	import tsn_pkg::*;

	localparam int DEPTH = 1 << ADDR_BITS;

	texel_t mem_a [DEPTH];
	texel_t mem_b [DEPTH];

	always_ff @(posedge clk) begin
		if (en && we) begin
			mem_a[waddr] <= wdata;
			mem_b[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rdata00 <= mem_a[raddr00];
			rdata10 <= mem_a[raddr10];
			rdata01 <= mem_b[raddr01];
			rdata11 <= mem_b[raddr11];
		end
	end

endmodule

[sv/texture_sampler_nearest_bilinear_core.sv]
// Texture sampler top level: config registers, coordinate pipeline, blend.
// Depends on tsn_pkg and tsn_texmem.
//
// Usage: items enter on the s_axis channel. tuser selects the function:
// 0 stores texel_rgba at texel_addr, 1 samples at (coord_u, coord_v).
// Each sample gives one transfer on m_axis with red..alpha in tdata;
// a texel write gives none. Registers are written over the APB port
// (byte address 4*index) while no item is in flight.
// A result reaches m_axis through stages 1 to 7 and the output register.
// Throughput: one item per cycle while m_tready does not hold the output;
// two mirrored dual-read store copies give all four bilinear taps at once.
// A write item updates the store in the same stage in which later
// samples read it, so reads always see earlier writes.
// Reset clears all valid bits and loads register reset values; the store
// content is undefined until written.
// When m_tready is low with a result held, the whole pipeline and the
// input channel hold; nothing is lost or repeated.
module texture_sampler_nearest_bilinear_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// [15:0] texel_addr, [47:16] texel_rgba, [71:48] coord_u, [95:72] coord_v
	input  logic [95:0]                   s_axis_tdata,
	// [0] func
	input  logic [0:0]                    s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
	output logic [31:0]                   m_axis_tdata,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tsn_pkg::PADDR_BITS-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import tsn_pkg::*;

	localparam int SX_BITS  = WC_BITS + DIM_BITS;
	localparam int HB_BITS  = 8 + FRAC_BITS;
	localparam int ACC_BITS = 8 + 2 * FRAC_BITS;

	logic [DIM_BITS-1:0] tex_width_q, tex_height_q;
	logic wrap_u_q, wrap_v_q, filter_q, present_q;
	logic [2:0] reg_idx;
	logic adv;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_width_q  <= DIM_BITS'(1);
			tex_height_q <= DIM_BITS'(1);
			wrap_u_q     <= 1'b0;
			wrap_v_q     <= 1'b0;
			filter_q     <= 1'b0;
			present_q    <= 1'b0;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_TEX_WIDTH:  tex_width_q  <= pwdata[DIM_BITS-1:0];
				REG_TEX_HEIGHT: tex_height_q <= pwdata[DIM_BITS-1:0];
				REG_WRAP_U:     wrap_u_q     <= pwdata[0];
				REG_WRAP_V:     wrap_v_q     <= pwdata[0];
				REG_FILTER:     filter_q     <= pwdata[0];
				REG_PRESENT:    present_q    <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_TEX_WIDTH:  prdata = 32'(tex_width_q);
			REG_TEX_HEIGHT: prdata = 32'(tex_height_q);
			REG_WRAP_U:     prdata = 32'(wrap_u_q);
			REG_WRAP_V:     prdata = 32'(wrap_v_q);
			REG_FILTER:     prdata = 32'(filter_q);
			REG_PRESENT:    prdata = 32'(present_q);
			default:        prdata = '0;
		endcase
	end

	logic [DIM_BITS-1:0] w_eff, h_eff, w_max, h_max, w_mul, h_mul;
	assign w_eff = eff_dim(tex_width_q);
	assign h_eff = eff_dim(tex_height_q);
	assign w_max = w_eff - DIM_BITS'(1);
	assign h_max = h_eff - DIM_BITS'(1);
	assign w_mul = filter_q ? w_max : w_eff;
	assign h_mul = filter_q ? h_max : h_eff;

	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	// stage 1: wrap and flip
	logic v_s1, f_s1;
	taddr_t waddr_s1;
	texel_t wdata_s1;
	logic [WC_BITS-1:0] u_s1, vv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (adv)
			v_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			f_s1     <= s_axis_tuser[0];
			waddr_s1 <= s_axis_tdata[15:0];
			wdata_s1 <= s_axis_tdata[47:16];
			u_s1     <= wrap_coord(s_axis_tdata[71:48], wrap_u_q);
			vv_s1    <= ONE_FX - wrap_coord(s_axis_tdata[95:72], wrap_v_q);
		end
	end

	// stage 2: scale by size
	logic v_s2, f_s2;
	taddr_t waddr_s2;
	texel_t wdata_s2;
	logic [SX_BITS-1:0] sx_s2, sy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (adv)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			f_s2     <= f_s1;
			waddr_s2 <= waddr_s1;
			wdata_s2 <= wdata_s1;
			sx_s2    <= SX_BITS'(u_s1) * SX_BITS'(w_mul);
			sy_s2    <= SX_BITS'(vv_s1) * SX_BITS'(h_mul);
		end
	end

	// stage 3: integer coordinates and weights
	logic v_s3, f_s3;
	taddr_t waddr_s3;
	texel_t wdata_s3;
	logic [IDX_BITS-1:0] x0_s3, x1_s3, y0_s3, y1_s3;
	logic [FRAC_BITS-1:0] tx_s3, ty_s3;
	logic [SX_BITS-FRAC_BITS-1:0] xi, yi;
	logic [IDX_BITS-1:0] x0_c, y0_c;

	assign xi   = sx_s2[SX_BITS-1:FRAC_BITS];
	assign yi   = sy_s2[SX_BITS-1:FRAC_BITS];
	assign x0_c = (xi > (SX_BITS-FRAC_BITS)'(w_max)) ? w_max[IDX_BITS-1:0] : xi[IDX_BITS-1:0];
	assign y0_c = (yi > (SX_BITS-FRAC_BITS)'(h_max)) ? h_max[IDX_BITS-1:0] : yi[IDX_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (adv)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			f_s3     <= f_s2;
			waddr_s3 <= waddr_s2;
			wdata_s3 <= wdata_s2;
			x0_s3    <= x0_c;
			y0_s3    <= y0_c;
			x1_s3    <= (DIM_BITS'(x0_c) + DIM_BITS'(1) > w_max) ? w_max[IDX_BITS-1:0]
				: x0_c + IDX_BITS'(1);
			y1_s3    <= (DIM_BITS'(y0_c) + DIM_BITS'(1) > h_max) ? h_max[IDX_BITS-1:0]
				: y0_c + IDX_BITS'(1);
			tx_s3    <= sx_s2[FRAC_BITS-1:0];
			ty_s3    <= sy_s2[FRAC_BITS-1:0];
		end
	end

	// stage 4: row bases
	logic v_s4, f_s4;
	taddr_t waddr_s4;
	texel_t wdata_s4;
	taddr_t base0_s4, base1_s4;
	logic [IDX_BITS-1:0] x0_s4, x1_s4;
	logic [FRAC_BITS-1:0] tx_s4, ty_s4;
	logic [IDX_BITS+DIM_BITS-1:0] prod0, prod1;

	assign prod0 = (IDX_BITS+DIM_BITS)'(y0_s3) * (IDX_BITS+DIM_BITS)'(w_eff);
	assign prod1 = (IDX_BITS+DIM_BITS)'(y1_s3) * (IDX_BITS+DIM_BITS)'(w_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (adv)
			v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			f_s4     <= f_s3;
			waddr_s4 <= waddr_s3;
			wdata_s4 <= wdata_s3;
			base0_s4 <= prod0[ADDR_BITS-1:0];
			base1_s4 <= prod1[ADDR_BITS-1:0];
			x0_s4    <= x0_s3;
			x1_s4    <= x1_s3;
			tx_s4    <= tx_s3;
			ty_s4    <= ty_s3;
		end
	end

	// stage 5: store access
	logic v_s5, f_s5;
	logic [FRAC_BITS-1:0] tx_s5, ty_s5;
	texel_t p00_s5, p10_s5, p01_s5, p11_s5;

	tsn_texmem u_mem (
		.clk     (clk),
		.en      (adv),
		.we      (v_s4 && f_s4 == FUNC_WRITE),
		.waddr   (waddr_s4),
		.wdata   (wdata_s4),
		.raddr00 (base0_s4 + ADDR_BITS'(x0_s4)),
		.raddr10 (base0_s4 + ADDR_BITS'(x1_s4)),
		.raddr01 (base1_s4 + ADDR_BITS'(x0_s4)),
		.raddr11 (base1_s4 + ADDR_BITS'(x1_s4)),
		.rdata00 (p00_s5),
		.rdata10 (p10_s5),
		.rdata01 (p01_s5),
		.rdata11 (p11_s5)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s5 <= 1'b0;
		else if (adv)
			v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			f_s5  <= f_s4;
			tx_s5 <= tx_s4;
			ty_s5 <= ty_s4;
		end
	end

	// stage 6: horizontal blend
	logic v_s6, f_s6;
	texel_t p00_s6;
	logic [FRAC_BITS-1:0] ty_s6;
	logic [HB_BITS-1:0] top_s6 [4];
	logic [HB_BITS-1:0] bot_s6 [4];
	logic [WC_BITS-1:0] itx;

	assign itx = ONE_FX - WC_BITS'(tx_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s6 <= 1'b0;
		else if (adv)
			v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			f_s6   <= f_s5;
			p00_s6 <= p00_s5;
			ty_s6  <= ty_s5;
			for (int k = 0; k < 4; k++) begin
				top_s6[k] <= HB_BITS'(p00_s5[8*k +: 8]) * HB_BITS'(itx)
					+ HB_BITS'(p10_s5[8*k +: 8]) * HB_BITS'(tx_s5);
				bot_s6[k] <= HB_BITS'(p01_s5[8*k +: 8]) * HB_BITS'(itx)
					+ HB_BITS'(p11_s5[8*k +: 8]) * HB_BITS'(tx_s5);
			end
		end
	end

	// stage 7: vertical blend
	logic v_s7, f_s7;
	texel_t p00_s7;
	logic [ACC_BITS-1:0] acc_s7 [4];
	logic [WC_BITS-1:0] ity;

	assign ity = ONE_FX - WC_BITS'(ty_s6);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s7 <= 1'b0;
		else if (adv)
			v_s7 <= v_s6;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			f_s7   <= f_s6;
			p00_s7 <= p00_s6;
			for (int k = 0; k < 4; k++)
				acc_s7[k] <= ACC_BITS'(top_s6[k]) * ACC_BITS'(ity)
					+ ACC_BITS'(bot_s6[k]) * ACC_BITS'(ty_s6);
		end
	end

	// output register: round, clamp, select
	logic [31:0] pix;
	logic [ACC_BITS:0] rnd [4];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			rnd[k] = (ACC_BITS+1)'(acc_s7[k]) + ((ACC_BITS+1)'(1) << (2*FRAC_BITS-1));
			pix[8*k +: 8] = (rnd[k][ACC_BITS:2*FRAC_BITS] > 9'd255) ? 8'hFF
				: rnd[k][2*FRAC_BITS +: 8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_axis_tvalid <= 1'b0;
		else if (adv)
			m_axis_tvalid <= v_s7 && f_s7 == FUNC_SAMPLE;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			priority if (!present_q)
				m_axis_tdata <= '1;
			else if (!filter_q)
				m_axis_tdata <= p00_s7;
			else
				m_axis_tdata <= pix;
		end
	end

endmodule

[bench/tb_texture_sampler_nearest_bilinear_core.sv]
// Testbench for texture_sampler_nearest_bilinear_core: drives texel writes and
// samples over the stream port, predicts each filtered texel, checks the results.
// Depends on tsn_pkg and the sampler RTL.
module tb_texture_sampler_nearest_bilinear_core;
	import tsn_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [95:0] s_axis_tdata = '0;
	logic [0:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [PADDR_BITS-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	texture_sampler_nearest_bilinear_core DUT (.*);

	always #1 clk = ~clk;

	logic [31:0] shadow_store [int];
	logic [8:0]  cfg_width, cfg_height;
	logic        cfg_wrap_u, cfg_wrap_v, cfg_linear, cfg_present;
	logic [31:0] expected_colors[$];
	int          mismatch_count = 0;
	int          cycle_count = 0;
	bit          sender_idles = 1'b1;
	bit          receiver_idles = 1'b1;
	int          hold_off_cycles = 0;
	int          long_hold_requests = 0;
	int          long_hold_seen = 0;
	int          long_hold_left = 0;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (long_hold_requests != long_hold_seen) begin
			long_hold_seen <= long_hold_requests;
			long_hold_left <= 60;
		end else if (long_hold_left > 0) begin
			long_hold_left <= long_hold_left - 1;
		end
	end

	always @(posedge clk) begin
		int burst;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (long_hold_left > 0) begin
			m_axis_tready <= 1'b0;
		end else if (hold_off_cycles > 0) begin
			hold_off_cycles <= hold_off_cycles - 1;
			m_axis_tready <= 1'b0;
		end else if (receiver_idles && $urandom_range(0, 7) == 0) begin
			burst = $urandom_range(1, 11);
			hold_off_cycles <= burst - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		logic [31:0] want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_colors.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result %h", m_axis_tdata);
			end else begin
				want = expected_colors.pop_front();
				for (int k = 0; k < 4; k++)
					if (m_axis_tdata[8*k +: 8] !== want[8*k +: 8]) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("channel %0d: expected %h actual %h", k,
								want[8*k +: 8], m_axis_tdata[8*k +: 8]);
					end
			end
		end
	end

	function automatic logic [31:0] fetch_texel(int x, int y, int w);
		int idx;
		idx = y * w + x;
		if (idx >= 65536 || !shadow_store.exists(idx))
			return '0;
		return shadow_store[idx];
	endfunction

	function automatic logic [16:0] fold_coord(logic signed [23:0] c, logic clamp_edge);
		if (!clamp_edge)
			return {1'b0, c[15:0]};
		if (c < 0)
			return 17'd0;
		if (c > 24'sd65536)
			return 17'h10000;
		return c[16:0];
	endfunction

	function automatic logic [31:0] filter_color(logic signed [23:0] cu,
		logic signed [23:0] cv);
		longint w, h, u, v, x0, y0, x1, y1, sx, sy, tx, ty, top, bot, acc, r;
		logic [31:0] p00, p10, p01, p11, res;
		if (!cfg_present)
			return 32'hFFFF_FFFF;
		w = (cfg_width == 0) ? 1 : (cfg_width > 256) ? 256 : cfg_width;
		h = (cfg_height == 0) ? 1 : (cfg_height > 256) ? 256 : cfg_height;
		u = fold_coord(cu, cfg_wrap_u);
		v = 65536 - fold_coord(cv, cfg_wrap_v);
		if (!cfg_linear) begin
			x0 = (u * w) >> 16;
			y0 = (v * h) >> 16;
			if (x0 > w - 1) x0 = w - 1;
			if (y0 > h - 1) y0 = h - 1;
			return fetch_texel(int'(x0), int'(y0), int'(w));
		end
		sx = u * (w - 1);
		sy = v * (h - 1);
		x0 = sx >> 16;
		y0 = sy >> 16;
		if (x0 > w - 1) x0 = w - 1;
		if (y0 > h - 1) y0 = h - 1;
		x1 = (x0 + 1 > w - 1) ? w - 1 : x0 + 1;
		y1 = (y0 + 1 > h - 1) ? h - 1 : y0 + 1;
		tx = sx - (x0 << 16);
		ty = sy - (y0 << 16);
		if (tx > 65536) tx = 65536;
		if (ty > 65536) ty = 65536;
		p00 = fetch_texel(int'(x0), int'(y0), int'(w));
		p10 = fetch_texel(int'(x1), int'(y0), int'(w));
		p01 = fetch_texel(int'(x0), int'(y1), int'(w));
		p11 = fetch_texel(int'(x1), int'(y1), int'(w));
		for (int k = 0; k < 4; k++) begin
			top = p00[8*k +: 8] * (65536 - tx) + p10[8*k +: 8] * tx;
			bot = p01[8*k +: 8] * (65536 - tx) + p11[8*k +: 8] * tx;
			acc = top * (65536 - ty) + bot * ty;
			r = (acc + (64'd1 << 31)) >> 32;
			res[8*k +: 8] = (r > 255) ? 8'd255 : r[7:0];
		end
		return res;
	endfunction

	task automatic send_item(logic fn, logic [15:0] addr, logic [31:0] rgba,
		logic [23:0] cu, logic [23:0] cv);
		int gap;
		if (sender_idles && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 11);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= fn;
		s_axis_tdata <= {cv, cu, rgba, addr};
		do @(posedge clk); while (!s_axis_tready);
		if (fn == FUNC_WRITE)
			shadow_store[addr] = rgba;
		else
			expected_colors.push_back(filter_color(cu, cv));
	endtask

	task automatic write_texel(int addr, logic [31:0] rgba);
		send_item(FUNC_WRITE, addr[15:0], rgba, 24'($urandom), 24'($urandom));
	endtask

	task automatic sample_at(logic [23:0] cu, logic [23:0] cv);
		send_item(FUNC_SAMPLE, 16'($urandom), $urandom, cu, cv);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (expected_colors.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_register(logic [2:0] index, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_BITS'({index, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		case (index)
			REG_TEX_WIDTH:  cfg_width = value[8:0];
			REG_TEX_HEIGHT: cfg_height = value[8:0];
			REG_WRAP_U:     cfg_wrap_u = value[0];
			REG_WRAP_V:     cfg_wrap_v = value[0];
			REG_FILTER:     cfg_linear = value[0];
			REG_PRESENT:    cfg_present = value[0];
			default: ;
		endcase
	endtask

	task automatic set_mode(int w, int h, bit wu, bit wv, bit lin, bit present);
		drain_results();
		write_register(REG_TEX_WIDTH, w);
		write_register(REG_TEX_HEIGHT, h);
		write_register(REG_WRAP_U, 32'(wu));
		write_register(REG_WRAP_V, 32'(wv));
		write_register(REG_FILTER, 32'(lin));
		write_register(REG_PRESENT, 32'(present));
	endtask

	// fill every texel a sample can reach for a w x h texture
	task automatic load_texture(int w, int h);
		for (int i = 0; i < w * h; i++)
			write_texel(i, $urandom);
	endtask

	function automatic logic [23:0] random_coord();
		case ($urandom_range(0, 3))
			0: return 24'($urandom);
			1: return 24'($urandom_range(0, 65536));
			2: return 24'($signed($urandom_range(0, 200000)) - 100000);
			default: return 24'($urandom_range(0, 65536) | (24'($urandom) & 24'hFF0000));
		endcase
	endfunction

	task automatic test_absent_texture();
		set_mode(1, 1, 1'b0, 1'b0, 1'b0, 1'b0);
		sample_at(24'h800000, 24'h7FFFFF);
		sample_at(24'h000000, 24'hFFFFFF);
	endtask

	task automatic test_directed_edges();
		load_texture(4, 4);
		write_texel(16'hFFFF, 32'hFFFF_FFFF);
		write_texel(16'h0000, 32'h0000_0000);
		set_mode(4, 4, 1'b0, 1'b0, 1'b0, 1'b1);
		sample_at(24'h000000, 24'h000000);
		sample_at(24'h00FFFF, 24'h010000);
		sample_at(24'h800000, 24'h7FFFFF);
		sample_at(24'hFFFFFF, 24'h008000);
		set_mode(4, 4, 1'b1, 1'b1, 1'b1, 1'b1);
		sample_at(24'h800000, 24'h7FFFFF);
		sample_at(24'h010000, 24'h000000);
		sample_at(24'h008000, 24'h008000);
		sample_at(24'h00AAAA, 24'hFFFFFF);
		// zero size acts as one texel
		set_mode(0, 0, 1'b0, 1'b1, 1'b1, 1'b1);
		sample_at(24'h123456, 24'h654321);
		// oversize treated as the largest texture; with height 1 only row 0 is reachable
		set_mode(511, 1, 1'b1, 1'b1, 1'b0, 1'b1);
		write_texel(0, $urandom);
		write_texel(255, $urandom);
		sample_at(24'h7FFFFF, 24'h010000);
		sample_at(24'h000000, 24'h010000);
		set_mode(256, 256, 1'b1, 1'b1, 1'b0, 1'b1);
		write_texel(65535, 32'h8040_20FF);
		sample_at(24'h7FFFFF, 24'h800000);
	endtask

	task automatic test_random_modes();
		int w, h;
		for (int phase = 0; phase < 12; phase++) begin
			w = (phase % 4 == 0) ? $urandom_range(1, 3) : $urandom_range(1, 8);
			h = (phase % 5 == 0) ? 1 : $urandom_range(1, 8);
			set_mode(w, h, 1'($urandom), 1'($urandom), 1'($urandom), phase != 7);
			if ($urandom_range(0, 1))
				write_register(REG_TEX_WIDTH, ($urandom & ~32'h1FF) | 32'(w));
			load_texture(w, h);
			for (int i = 0; i < 30; i++)
				if ($urandom_range(0, 4) == 0)
					write_texel($urandom_range(0, w * h - 1), $urandom);
				else
					sample_at(random_coord(), random_coord());
		end
	endtask

	task automatic test_backpressure();
		set_mode(5, 3, 1'b0, 1'b1, 1'b1, 1'b1);
		@(posedge clk);
		long_hold_requests++;
		for (int i = 0; i < 40; i++)
			sample_at(random_coord(), random_coord());
	endtask

	task automatic test_full_rate();
		sender_idles = 1'b0;
		receiver_idles = 1'b0;
		set_mode(7, 6, 1'b1, 1'b0, 1'b1, 1'b1);
		load_texture(7, 6);
		for (int i = 0; i < 80; i++)
			sample_at(random_coord(), random_coord());
	endtask

	initial begin
		cfg_width = 9'd1;
		cfg_height = 9'd1;
		cfg_wrap_u = 1'b0;
		cfg_wrap_v = 1'b0;
		cfg_linear = 1'b0;
		cfg_present = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_absent_texture();
		test_directed_edges();
		test_random_modes();
		test_backpressure();
		test_full_rate();
		drain_results();
		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
